// File: hw/rtl/motor_drive_frame_sender_core_defines.svh
// assertion macros for the frame sender rtl
`ifndef MOTOR_DRIVE_FRAME_SENDER_CORE_DEFINES_SVH
`define MOTOR_DRIVE_FRAME_SENDER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MDFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MDFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mdfs_pkg.sv
// types, constants and crc function of the frame sender
`default_nettype none

package mdfs_pkg;

  localparam int MAX_WORDS = 4;
  localparam int WIDX_W    = $clog2(MAX_WORDS);
  localparam int LEN_W     = 2;
  // counter covers both the crc byte steps and the transmit burst
  localparam int CNT_W     = $clog2(2 * (MAX_WORDS + 2) + 1);

  localparam logic [7:0]  ANS_OK          = 8'h4F;
  localparam logic [7:0]  ANS_FAIL        = 8'h46;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [7:0]  NODE_ID_RST     = 8'd1;
  localparam logic [15:0] TIMEOUT_RST     = 16'd500;
  localparam logic [3:0]  MAX_ATTEMPT_RST = 4'd6;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_RX    = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_OP_REFUSED    = 3'd1,
    ST_OP_ODD        = 3'd2,
    ST_FRAME_REFUSED = 3'd3,
    ST_FRAME_ODD     = 3'd4,
    ST_NO_ANSWER     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_NODE_ID      = 2'd0,
    CFG_TIMEOUT      = 2'd1,
    CFG_MAX_ATTEMPTS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic    load_frame;
    logic    crc_step;
    logic    clr_wait;
    logic    tick_wait;
    logic    inc_attempt;
    logic    burst_clr;
    logic    burst_emit;
    logic    single_emit;
    logic    single_is_status;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic crc_last;
    logic burst_last;
    logic out_free;
    logic attempts_used;
    logic timed_out;
  } dp_stat_t;

  // eight msb-first crc steps, data bit shifted in at the bottom
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        carry;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      carry = c[15];
      c     = {c[14:0], b[i]};
      if (carry) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/motor_drive_frame_sender_core.sv
// frame sender top level: controller, datapath and result checks
//
//   channel   handshake              payload
//   in        in_valid_i/in_ready_o  mode, opcode, word_count_less_one, data_word0..3, rx_byte
//   out       out_valid_o/out_ready_i kind, tx_byte, status, last
//   cfg       cfg_we_i               cfg_idx_i, cfg_data_i (no wait, no read-back)
//
// a start passes through S_CRC, S_TRY and S_EMIT: the crc unit folds one byte per cycle
// a received 'O' sends 2*len+5 bytes, one per cycle while the output is taken
// a tick passes through S_TICK, and on a timeout S_TRY and S_EMIT for a resend; an answer
// that ends the frame passes through S_EMIT, and ignored items stay in S_IN
// one item at a time: in_ready_o is low until its results are all loaded
// the output register lets the next item in while the last result waits
// reset clears control, counters and config to defaults; no clearing pass
`default_nettype none
`include "motor_drive_frame_sender_core_defines.svh"

module motor_drive_frame_sender_core import mdfs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [15:0]      cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [7:0]       opcode_i,
  input  wire logic [LEN_W-1:0] word_count_less_one_i,
  input  wire logic [15:0]      data_word0_i,
  input  wire logic [15:0]      data_word1_i,
  input  wire logic [15:0]      data_word2_i,
  input  wire logic [15:0]      data_word3_i,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  kind_o,
  output logic [7:0]            tx_byte_o,
  output logic [2:0]            status_o,
  output logic                  last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .rx_byte_i  (rx_byte_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mdfs_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .opcode_i              (opcode_i),
    .word_count_less_one_i (word_count_less_one_i),
    .data_word0_i          (data_word0_i),
    .data_word1_i          (data_word1_i),
    .data_word2_i          (data_word2_i),
    .data_word3_i          (data_word3_i),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .kind_o                (kind_o),
    .tx_byte_o             (tx_byte_o),
    .status_o              (status_o),
    .last_o                (last_o)
  );

  // a finish result carries no byte and always closes the item
  `MDFS_ASSERT_IMP(a_finish_shape, out_valid_o && kind_o, (tx_byte_o == 8'h00) && last_o, "finish result malformed")
  // a byte result carries no status
  `MDFS_ASSERT_IMP(a_byte_status, out_valid_o && !kind_o, status_o == ST_OK, "byte result has status")
  // mid-burst no new item is taken
  `MDFS_ASSERT_IMP(a_burst_hold, out_valid_o && !last_o, !in_ready_o, "input taken mid-burst")
  // a burst keeps the output filled until its last byte
  `MDFS_ASSERT_NXT(a_burst_cont, out_valid_o && !last_o, out_valid_o, "gap inside burst")

endmodule

`default_nettype wire

// File: hw/rtl/mdfs_dp.sv
// frame sender datapath: config, frame store, crc, counters, result register
`default_nettype none

module mdfs_dp import mdfs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic [7:0]        opcode_i,
  input  wire logic [LEN_W-1:0]  word_count_less_one_i,
  input  wire logic [15:0]       data_word0_i,
  input  wire logic [15:0]       data_word1_i,
  input  wire logic [15:0]       data_word2_i,
  input  wire logic [15:0]       data_word3_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_stat_t               stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   kind_o,
  output logic [7:0]             tx_byte_o,
  output logic [2:0]             status_o,
  output logic                   last_o
);

  logic [7:0]       node_id_q;
  logic [15:0]      timeout_q;
  logic [3:0]       max_att_q;
  logic [7:0]       opcode_q;
  logic [LEN_W-1:0] len_q;
  logic [15:0]      words_q [MAX_WORDS];
  logic [15:0]      crc_q;
  logic [3:0]       attempt_q;
  logic [15:0]      wait_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             kind_q;
  logic [7:0]       tx_q;
  logic [2:0]       status_q;
  logic             last_q;

  logic [LEN_W-1:0] len_in;
  logic [CNT_W-1:0] len_ext;
  logic [CNT_W-1:0] wi;
  logic [CNT_W-1:0] bm;
  logic [15:0]      crc_word;
  logic [7:0]       crc_in;
  logic [15:0]      bw;
  logic [7:0]       burst_byte;
  logic             out_free;

  assign len_in  = (word_count_less_one_i > LEN_W'(MAX_WORDS - 1)) ?
                   LEN_W'(MAX_WORDS - 1) : word_count_less_one_i;
  assign len_ext = CNT_W'(len_q);

  // crc walks header, data words, zero word, high byte first
  always_comb begin
    wi = cnt_q >> 1;
    if (wi == '0) begin
      crc_word = {opcode_q, {(8 - LEN_W){1'b0}}, len_q};
    end else if (wi <= len_ext + CNT_W'(1)) begin
      crc_word = words_q[WIDX_W'(wi - CNT_W'(1))];
    end else begin
      crc_word = 16'h0000;
    end
    crc_in = cnt_q[0] ? crc_word[7:0] : crc_word[15:8];
  end

  // burst: len byte, words low byte first, crc low then high
  always_comb begin
    bm = cnt_q - CNT_W'(1);
    bw = words_q[WIDX_W'(bm >> 1)];
    if (cnt_q == '0) begin
      burst_byte = {{(8 - LEN_W){1'b0}}, len_q};
    end else if (cnt_q <= (len_ext << 1) + CNT_W'(2)) begin
      burst_byte = bm[0] ? bw[15:8] : bw[7:0];
    end else if (cnt_q == (len_ext << 1) + CNT_W'(3)) begin
      burst_byte = crc_q[7:0];
    end else begin
      burst_byte = crc_q[15:8];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.crc_last      = (cnt_q == (len_ext << 1) + CNT_W'(5));
  assign stat_o.burst_last    = (cnt_q == (len_ext << 1) + CNT_W'(4));
  assign stat_o.out_free      = out_free;
  assign stat_o.attempts_used = (attempt_q >= max_att_q);
  assign stat_o.timed_out     = (wait_q >= timeout_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= NODE_ID_RST;
      timeout_q   <= TIMEOUT_RST;
      max_att_q   <= MAX_ATTEMPT_RST;
      opcode_q    <= '0;
      len_q       <= '0;
      crc_q       <= '0;
      attempt_q   <= '0;
      wait_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_ID:      node_id_q <= cfg_data_i[7:0];
          CFG_TIMEOUT:      timeout_q <= cfg_data_i;
          CFG_MAX_ATTEMPTS: max_att_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.load_frame) begin
        opcode_q  <= opcode_i;
        len_q     <= len_in;
        crc_q     <= '0;
        attempt_q <= '0;
        cnt_q     <= '0;
      end else if (cmd_i.crc_step) begin
        crc_q <= crc_byte(crc_q, crc_in);
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.burst_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.burst_emit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.inc_attempt) begin
        attempt_q <= attempt_q + 4'd1;
      end
      if (cmd_i.clr_wait) begin
        wait_q <= '0;
      end else if (cmd_i.tick_wait && wait_q != 16'hFFFF) begin
        wait_q <= wait_q + 16'd1;
      end
      if (cmd_i.burst_emit || cmd_i.single_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame words and result payload carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      words_q[0] <= data_word0_i;
      words_q[1] <= {node_id_q, data_word1_i[7:0]};
      words_q[2] <= data_word2_i;
      words_q[3] <= data_word3_i;
    end
    if (cmd_i.burst_emit) begin
      kind_q   <= 1'b0;
      tx_q     <= burst_byte;
      status_q <= ST_OK;
      last_q   <= stat_o.burst_last;
    end else if (cmd_i.single_emit) begin
      kind_q   <= cmd_i.single_is_status;
      tx_q     <= cmd_i.single_is_status ? 8'h00 : opcode_q;
      status_q <= cmd_i.single_is_status ? cmd_i.status : ST_OK;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = tx_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/mdfs_ctrl.sv
// frame sender controller: link phase and sequencing of datapath commands
`default_nettype none

module mdfs_ctrl import mdfs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IN,
    S_CRC,
    S_TICK,
    S_TRY,
    S_EMIT,
    S_BURST
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_OP,
    PH_WAIT_FRAME
  } phase_e;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  logic    is_status_q, is_status_d;
  status_e status_q, status_d;
  mode_e   mode;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == S_IN);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    is_status_d = is_status_q;
    status_d    = status_q;
    cmd_o       = '0;
    cmd_o.single_is_status = is_status_q;
    cmd_o.status           = status_q;
    case (state_q)
      S_IN: begin
        if (in_valid_i) begin
          case (mode)
            MODE_START: begin
              if (phase_q == PH_IDLE) begin
                cmd_o.load_frame = 1'b1;
                state_d          = S_CRC;
              end
            end
            MODE_RX: begin
              if (phase_q == PH_WAIT_OP) begin
                cmd_o.clr_wait = 1'b1;
                if (rx_byte_i == ANS_OK) begin
                  cmd_o.burst_clr = 1'b1;
                  phase_d         = PH_WAIT_FRAME;
                  state_d         = S_BURST;
                end else begin
                  phase_d     = PH_IDLE;
                  is_status_d = 1'b1;
                  status_d    = (rx_byte_i == ANS_FAIL) ? ST_OP_REFUSED : ST_OP_ODD;
                  state_d     = S_EMIT;
                end
              end else if (phase_q == PH_WAIT_FRAME) begin
                cmd_o.clr_wait = 1'b1;
                phase_d        = PH_IDLE;
                is_status_d    = 1'b1;
                if (rx_byte_i == ANS_OK) begin
                  status_d = ST_OK;
                end else if (rx_byte_i == ANS_FAIL) begin
                  status_d = ST_FRAME_REFUSED;
                end else begin
                  status_d = ST_FRAME_ODD;
                end
                state_d = S_EMIT;
              end
            end
            MODE_TICK: begin
              if (phase_q != PH_IDLE) begin
                cmd_o.tick_wait = 1'b1;
                state_d         = S_TICK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (stat_i.crc_last) begin
          state_d = S_TRY;
        end
      end
      S_TICK: begin
        state_d = stat_i.timed_out ? S_TRY : S_IN;
      end
      S_TRY: begin
        cmd_o.clr_wait = 1'b1;
        if (stat_i.attempts_used) begin
          phase_d     = PH_IDLE;
          is_status_d = 1'b1;
          status_d    = ST_NO_ANSWER;
        end else begin
          cmd_o.inc_attempt = 1'b1;
          phase_d           = PH_WAIT_OP;
          is_status_d       = 1'b0;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.single_emit = 1'b1;
          state_d           = S_IN;
        end
      end
      S_BURST: begin
        if (stat_i.out_free) begin
          cmd_o.burst_emit = 1'b1;
          if (stat_i.burst_last) begin
            state_d = S_IN;
          end
        end
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      phase_q     <= PH_IDLE;
      is_status_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      is_status_q <= is_status_d;
      status_q    <= status_d;
    end
  end

endmodule

`default_nettype wire
